[rtl/core/tsdf_pkg.sv]
// Package for the TSDF cell fusion block.
// Holds the controller state type and command/status types shared with datapath.
package tsdf_pkg;
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_DEN, S_DIV1, S_PROD, S_DIV2, S_WRITE, S_OUT
    } t_state;

    localparam logic [1:0] MODE_CONST  = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_QUAD   = 2'd2;
    localparam logic [1:0] MODE_ZERO   = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_TRUNC = 2'd1;
    localparam logic [1:0] REG_BEHIND = 2'd2;
    localparam logic [1:0] REG_BASE  = 2'd3;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic read;
        logic den;
        logic div1_start;
        logic prod;
        logic div2_start;
        logic write;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_done;
    } t_status;
endpackage

[rtl/core/tsdf_if.sv]
// Valid/ready stream interface with a payload of parameterized type.
// Depends on nothing.
interface tsdf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/tsdf_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing.
module tsdf_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic [W-1:0] o_quot,
    output logic         o_done
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0] r_q, n_q, r_d;
    logic [W:0]   r_rem, n_rem, w_trial;
    logic [CW-1:0] r_cnt;
    logic         r_busy;

    always_comb begin
        w_trial = {r_rem[W-1:0], r_q[W-1]};
        n_q = {r_q[W-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_d}) begin
            n_rem = w_trial - {1'b0, r_d};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(W);
            r_q <= i_num;
            r_d <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    // The full quotient is present while o_done is high.
    assign o_quot = n_q;
    assign o_done = r_busy && (r_cnt == CW'(1));
endmodule

[rtl/core/tsdf_datapath.sv]
// Datapath: cell stores, weight and fusion arithmetic, shared divider.
// Depends on tsdf_pkg and tsdf_div.
module tsdf_datapath #(
    parameter int AW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tsdf_pkg::t_cmd       i_cmd,
    output tsdf_pkg::t_status    o_status,
    input  logic [AW-1:0]        i_addr,
    input  logic signed [15:0]   i_s,
    input  logic [15:0]          i_len,
    input  logic [1:0]           i_mode,
    input  logic [14:0]          i_trunc,
    input  logic [14:0]          i_behind,
    input  logic [15:0]          i_base,
    output logic signed [15:0]   o_dist,
    output logic [31:0]          o_weight
);
    import tsdf_pkg::*;
    localparam int DEPTH = 1 << AW;

    logic signed [15:0] r_dmem [DEPTH];
    logic [31:0]        r_wmem [DEPTH];
    logic [AW-1:0] r_addr, r_clr;
    logic signed [15:0] r_s, r_d;
    logic [31:0] r_w;
    logic [63:0] r_scale, r_den, r_num1, r_den1, r_u, r_tot;
    logic signed [63:0] r_fnum;
    logic r_neg, r_taper, r_zero;
    logic [63:0] w_num, w_dd, w_q;
    logic w_start, w_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            r_dmem[r_clr] <= '0;
            r_wmem[r_clr] <= '0;
        end else if (i_cmd.write) begin
            r_dmem[r_addr] <= o_dist;
            r_wmem[r_addr] <= o_weight;
        end
        if (i_cmd.read) begin
            r_d <= r_dmem[r_addr];
            r_w <= r_wmem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.clear_wr) r_clr <= r_clr + 1'b1;
    end
    assign o_status = '{clear_last: (r_clr == {AW{1'b1}}), div_done: w_done};

    logic signed [17:0] w_spt, w_negb;
    logic [15:0] w_lenf;
    logic [31:0] w_lensq;
    assign w_spt  = 18'(i_s) + 18'($signed({1'b0, i_trunc}));
    assign w_negb = -18'($signed({1'b0, i_behind}));
    assign w_lenf = (i_len == 16'd0) ? 16'd1 : i_len;
    assign w_lensq = 32'(w_lenf) * 32'(w_lenf);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_addr;
            r_s <= i_s;
            r_zero <= (i_mode == MODE_ZERO);
            r_taper <= 18'(i_s) < w_negb;
            r_neg <= !(w_spt > 0 && i_trunc > i_behind);
            r_num1 <= 64'(w_spt[16:0]);
            r_den1 <= 64'(i_trunc - i_behind);
            unique case (i_mode)
                MODE_CONST:  r_scale <= 64'(i_base) << 8;
                MODE_LINEAR: r_scale <= 64'(i_base) << 16;
                default:     r_scale <= 64'(i_base) << 24;
            endcase
            r_den <= (i_mode == MODE_QUAD) ? 64'(w_lensq) :
                     ((i_mode == MODE_LINEAR) ? 64'(w_lenf) : 64'd1);
        end
        if (i_cmd.den) begin
            if (r_taper) begin
                r_scale <= 64'(r_scale[40:0] * r_num1[16:0]);
                r_den <= 64'(r_den[31:0] * r_den1[14:0]);
            end
        end
        if (i_cmd.prod) begin
            r_tot <= 64'(r_w) + r_u;
            r_fnum <= 64'(r_d) * 64'($signed({1'b0, r_w}))
                    + 64'(r_s) * 64'($signed({1'b0, r_u[31:0]}));
        end
    end

    logic r_u_pend, r_phase2;
    logic [63:0] w_uq;
    assign w_uq = (r_zero || (r_taper && r_neg)) ? 64'd0 :
                  ((w_q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : w_q);
    always_ff @(posedge i_clk) begin
        if (w_done && !i_cmd.div2_start && r_u_pend) r_u <= w_uq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_pend <= 1'b0;
            r_phase2 <= 1'b0;
        end else begin
            if (i_cmd.div1_start) r_u_pend <= 1'b1;
            else if (w_done) r_u_pend <= 1'b0;
            if (i_cmd.div2_start) r_phase2 <= 1'b1;
            else if (w_done) r_phase2 <= 1'b0;
        end
    end

    logic r_started;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_started <= 1'b0;
        else r_started <= i_cmd.div1_start;
    end

    logic w_nsign;
    logic [63:0] w_anum;
    assign w_nsign = r_fnum[63];
    assign w_anum = w_nsign ? 64'(-r_fnum) : 64'(r_fnum);
    assign w_start = r_started || i_cmd.div2_start;
    assign w_num = r_phase2 || i_cmd.div2_start ? w_anum : r_scale;
    assign w_dd  = r_phase2 || i_cmd.div2_start ? r_tot : r_den;

    tsdf_div #(.W(64)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_dd), .o_quot(w_q), .o_done(w_done)
    );

    logic signed [15:0] r_nd;
    always_ff @(posedge i_clk) begin
        if (w_done && r_phase2) begin
            r_nd <= (r_tot == 64'd0) ? r_d : (w_nsign ? 16'(-w_q) : 16'(w_q));
        end
    end
    assign o_dist = r_nd;
    assign o_weight = (r_tot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r_tot[31:0];
endmodule

[rtl/core/tsdf_ctrl.sv]
// Controller state machine sequencing clear, read, divides and write-back.
// Depends on tsdf_pkg.
module tsdf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tsdf_pkg::t_status i_status,
    output tsdf_pkg::t_cmd    o_cmd
);
    import tsdf_pkg::*;
    t_state r_state, n_state;
    logic r_prod_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prod_d <= 1'b0;
        else r_prod_d <= (r_state == S_PROD);
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.div2_start = r_prod_d;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state = S_DEN;
            end
            S_DEN: begin
                o_cmd.den = 1'b1;
                n_state = S_DIV1;
                o_cmd.div1_start = 1'b1;
            end
            S_DIV1: if (i_status.div_done) n_state = S_PROD;
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                if (i_status.div_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready during output");
    a_write_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.write |=> o_out_valid) else $error("output missing after write");
`endif
endmodule

[rtl/core/tsdf_cell_fusion.sv]
// TSDF cell fusion top level: one item at a time; the next input is taken only after the
// output transfer. Each item makes two passes through the shared 64-step restoring divider.
// After reset a clearing pass of one cycle per store entry (65536 at the default GRID_DIM)
// zeroes the stores; no item is accepted during it, configuration writes are taken.
// Depends on tsdf_pkg, tsdf_if, tsdf_ctrl and tsdf_datapath.
module tsdf_cell_fusion #(
    parameter int GRID_DIM = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    tsdf_if.sink        i_in,
    tsdf_if.source      o_out
);
    import tsdf_pkg::*;
    localparam int CB = $clog2(GRID_DIM);
    localparam int WRAP_K = 20;
    localparam int WRAP_M = ((1 << WRAP_K) + GRID_DIM - 1) / GRID_DIM;

    logic [1:0] r_mode;
    logic [14:0] r_trunc, r_behind;
    logic [15:0] r_base;
    t_cmd w_cmd;
    t_status w_status;

    // Coordinates wrap modulo GRID_DIM through a reciprocal multiplication.
    function automatic logic [CB-1:0] f_wrap(input logic [7:0] v);
        logic [27:0] v_prod;
        logic [17:0] v_rem;
        v_prod = 28'(v) * 28'(WRAP_M);
        v_rem = 18'(v) - 18'(v_prod[27:WRAP_K]) * 18'(GRID_DIM);
        return v_rem[CB-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd0;
            r_trunc <= 15'd77;
            r_behind <= 15'd26;
            r_base <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:   r_mode <= i_cfg_data[1:0];
                REG_TRUNC:  r_trunc <= i_cfg_data[14:0];
                REG_BEHIND: r_behind <= i_cfg_data[14:0];
                default:    r_base <= i_cfg_data;
            endcase
        end
    end

    logic [CB-1:0] w_x, w_y;
    assign w_x = f_wrap(i_in.data.cell_x);
    assign w_y = f_wrap(i_in.data.cell_y);

    tsdf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_status(w_status), .o_cmd(w_cmd)
    );

    tsdf_datapath #(.AW(2 * CB)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_addr({w_y, w_x}), .i_s(i_in.data.sample_dist), .i_len(i_in.data.ray_len),
        .i_mode(r_mode), .i_trunc(r_trunc), .i_behind(r_behind), .i_base(r_base),
        .o_dist(o_out.data.new_dist), .o_weight(o_out.data.new_weight)
    );
endmodule
